// ===== sv/stepper_trapezoid_ramp_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stepper trapezoid ramp core
// Shared property forms; each use expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_CORE_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stpr_pkg.sv =====
// ---------------------------------------------------------------------------
// stpr_pkg
// Shared widths, codes and types of the stepper trapezoid ramp core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpr_pkg;

  // Divider operand widths: widest dividend is a 32x16 product, widest
  // divisor is the magnitude of 4n+1 for a 32-bit signed n.
  localparam int DVD_W = 48;
  localparam int DVS_W = 34;

  typedef logic [DVD_W-1:0] dvd_t;
  typedef logic [DVS_W-1:0] dvs_t;

  // Motion phases.
  localparam logic [1:0] PH_STOP  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_DECEL = 2'd3;

  // Command kinds.
  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [7:0] CFG_MIN_DELAY_SCALE   = 8'd0;
  localparam logic [7:0] CFG_FIRST_DELAY_SCALE = 8'd1;
  localparam logic [7:0] CFG_SQRT_NUMERATOR    = 8'd2;
  localparam logic [7:0] CFG_MAX_STEP_SCALE    = 8'd3;

endpackage

// ===== sv/stepper_trapezoid_ramp_core.sv =====
// ---------------------------------------------------------------------------
// stepper_trapezoid_ramp_core
// Trapezoidal step-rate generator built around one shared serial divider.
// ---------------------------------------------------------------------------
// A move runs five divides, a square root and two reciprocal multiplies; the
// fifth divide is skipped when the brake length follows the acceleration
// share. A one- or zero-step move, or a tick in stop or run, uses no divide;
// a tick in accel or decel uses one. One word is in flight at a time, and an
// output stall holds the sequencer in its done state.
// Reset (rst_n low, synchronous) stops the motor and loads default scales.
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_core
  import stpr_pkg::*;
#(
  parameter int DELAY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, from bit 0: step_count_signed[23:0], accel_rate[39:24],
  // decel_rate[55:40], top_speed[71:56].
  input  logic [71:0] in_tdata,
  // tuser: cmd (0 move, 1 tick).
  input  logic        in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, from bit 0: period_ticks[31:0], compare_ticks[62:32],
  // pulse_enable[63], direction[64], busy_res[65], phase[67:66], zero pad.
  output logic [71:0] out_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Largest delay the timer can take.
  localparam logic [49:0] DMAX = (50'd1 << DELAY_BITS) - 50'd1;

  // Division by 100 of a value below 2^32: drop two bits, then multiply by
  // ceil(2^36 / 25) and keep the bits from 36 up. This is exact over that range.
  localparam logic [31:0] RECIP_100 = 32'd2748779070;

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MV0    = 5'd1;
  localparam logic [4:0] S_MV1W   = 5'd2;
  localparam logic [4:0] S_SQW    = 5'd3;
  localparam logic [4:0] S_SQ     = 5'd4;
  localparam logic [4:0] S_SQ_END = 5'd5;
  localparam logic [4:0] S_FD_DIV = 5'd6;
  localparam logic [4:0] S_FD_W   = 5'd7;
  localparam logic [4:0] S_DV_DIV = 5'd8;
  localparam logic [4:0] S_DV_W   = 5'd9;
  localparam logic [4:0] S_TL_DIV = 5'd10;
  localparam logic [4:0] S_TL_W   = 5'd11;
  localparam logic [4:0] S_AL_DIV = 5'd12;
  localparam logic [4:0] S_AL_W   = 5'd13;
  localparam logic [4:0] S_BL_DIV = 5'd14;
  localparam logic [4:0] S_BL_W   = 5'd15;
  localparam logic [4:0] S_MV_END = 5'd16;
  localparam logic [4:0] S_TK0    = 5'd17;
  localparam logic [4:0] S_TK_W   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  // Clamp a signed value into the delay range.
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic signed [49:0] v);
    logic [DELAY_BITS-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if ($unsigned(v) > DMAX) begin
      res = DMAX[DELAY_BITS-1:0];
    end else begin
      res = v[DELAY_BITS-1:0];
    end
    return res;
  endfunction

  logic [4:0]            state_r;

  // Scale registers.
  logic [31:0]           cfg_min_scale_r;
  logic [15:0]           cfg_fd_scale_r;
  logic [31:0]           cfg_sq_num_r;
  logic [15:0]           cfg_ms_scale_r;

  // Ramp state.
  logic [1:0]            phase_r;
  logic                  dir_r;
  logic                  busy_r;
  logic [DELAY_BITS-1:0] delay_r;
  logic [DELAY_BITS-1:0] min_delay_r;
  logic [DELAY_BITS-1:0] last_delay_r;
  logic [31:0]           ramp_r;
  logic [31:0]           brake_len_r;
  logic [31:0]           brake_start_r;
  logic [31:0]           steps_done_r;
  logic [31:0]           rem_r;

  // Move operands and intermediate results.
  logic [23:0]           op_steps_r;
  logic [15:0]           op_acc_r;
  logic [15:0]           op_dec_r;
  logic [15:0]           op_spd_r;
  logic [63:0]           mul_r;
  logic [31:0]           divq_r;
  logic [31:0]           top_lim_r;
  logic [31:0]           blen_r;
  logic                  den_neg_r;
  logic [31:0]           sq_rem_r;
  logic [31:0]           sq_res_r;
  logic [30:0]           sq_bit_r;

  // Result staging and output register.
  logic [31:0]           pend_period_r;
  logic [30:0]           pend_cmp_r;
  logic                  pend_pe_r;
  logic                  out_valid_r;
  logic [31:0]           out_period_r;
  logic [30:0]           out_cmp_r;
  logic                  out_pe_r;
  logic                  out_dir_r;
  logic                  out_busy_r;
  logic [1:0]            out_phase_r;

  // Shared divider and multiplier.
  logic                  div_start;
  dvd_t                  div_dvd;
  dvs_t                  div_dvs;
  logic                  div_done;
  dvd_t                  div_q;
  dvs_t                  div_r;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [27:0]           recip_q;

  // Input decode.
  logic                  in_acc;
  logic [23:0]           raw_steps;
  logic [23:0]           abs_steps;
  logic [15:0]           in_acc_rate;
  logic [15:0]           in_dec_rate;
  logic [15:0]           in_spd;

  // Square root step, tick recurrence and move helpers.
  logic [32:0]           sq_trial;
  logic                  sq_take;
  logic [31:0]           sq_root;
  logic [31:0]           n_next;
  logic signed [34:0]    den_s;
  logic [33:0]           den_abs;
  logic [33:0]           tick_num;
  logic [31:0]           sd_inc;
  logic signed [49:0]    q_signed;
  logic [DELAY_BITS-1:0] tick_next;
  logic [31:0]           rem_sat;
  logic [31:0]           q_nz;

  stpr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign raw_steps   = in_tdata[23:0];
  assign abs_steps   = raw_steps[23] ? 24'(25'h1000000 - {1'b0, raw_steps}) : raw_steps;
  // A zero rate or speed counts as one.
  assign in_acc_rate = (in_tdata[39:24] == '0) ? 16'd1 : in_tdata[39:24];
  assign in_dec_rate = (in_tdata[55:40] == '0) ? 16'd1 : in_tdata[55:40];
  assign in_spd      = (in_tdata[71:56] == '0) ? 16'd1 : in_tdata[71:56];

  // One bit-pair of the square root per cycle.
  assign sq_trial = {1'b0, sq_res_r} + {2'b00, sq_bit_r};
  assign sq_take  = (sq_trial <= {1'b0, sq_rem_r});
  assign sq_root  = (sq_res_r < sq_rem_r) ? sq_res_r + 32'd1 : sq_res_r;

  // Ramp recurrence divisor 4n+1 with n the incremented ramp index; it is
  // negative during braking, so its magnitude goes to the divider.
  assign n_next   = ramp_r + 32'd1;
  assign den_s    = {n_next[31], n_next, 2'b01};
  assign den_abs  = den_s[34] ? 34'(-den_s) : den_s[33:0];
  assign tick_num = {1'b0, 33'(delay_r)} + {1'b0, 33'(delay_r)} + {2'b00, rem_r};
  assign sd_inc   = steps_done_r + 32'd1;

  // Truncating signed division: the quotient takes the divisor's sign and
  // the remainder stays non-negative since the dividend is.
  assign q_signed  = den_neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign tick_next = sat_delay($signed({18'd0, 32'(delay_r)}) - q_signed);
  assign rem_sat   = (div_r[33:32] != 2'b00) ? 32'hFFFF_FFFF : div_r[31:0];
  assign q_nz      = (div_q == '0) ? 32'd1 : div_q[31:0];

  // Quotient of the last reciprocal multiply.
  assign recip_q = mul_r[63:36];

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 34'd1;
    unique case (state_r)
      S_MV0: begin
        if (op_steps_r > 24'd1) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(cfg_min_scale_r);
          div_dvs   = DVS_W'(op_spd_r);
        end
      end
      S_MV1W: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(cfg_sq_num_r);
          div_dvs   = DVS_W'(op_acc_r);
        end
      end
      S_TL_DIV: begin
        div_start = 1'b1;
        div_dvd   = mul_r[DVD_W-1:0];
        div_dvs   = DVS_W'(divq_r);
      end
      S_AL_DIV: begin
        div_start = 1'b1;
        div_dvd   = mul_r[DVD_W-1:0];
        div_dvs   = DVS_W'({1'b0, op_acc_r} + {1'b0, op_dec_r});
      end
      S_BL_DIV: begin
        div_start = 1'b1;
        div_dvd   = mul_r[DVD_W-1:0];
        div_dvs   = DVS_W'(op_dec_r);
      end
      S_TK0: begin
        if (phase_r == PH_ACCEL || phase_r == PH_DECEL) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(tick_num);
          div_dvs   = den_abs;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Multiplier operand selection; the product is registered every cycle
  // and picked up by the state that follows.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ_END: begin
        mul_a = 32'(cfg_fd_scale_r);
        mul_b = sq_root;
      end
      S_FD_DIV, S_DV_DIV: begin
        // The product just formed is below 2^32; divide it by 100.
        mul_a = RECIP_100;
        mul_b = {2'b00, mul_r[31:2]};
      end
      S_FD_W: begin
        mul_a = 32'(cfg_ms_scale_r);
        mul_b = 32'(op_acc_r);
      end
      S_DV_W: begin
        mul_a = 32'(op_spd_r);
        mul_b = 32'(op_spd_r);
      end
      S_TL_W: begin
        mul_a = 32'(op_dec_r);
        mul_b = 32'(op_steps_r);
      end
      S_AL_W: begin
        mul_a = top_lim_r;
        mul_b = 32'(op_acc_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_scale_r <= 32'd3141592;
      cfg_fd_scale_r  <= 16'd6760;
      cfg_sq_num_r    <= 32'd628318530;
      cfg_ms_scale_r  <= 16'd628;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_DELAY_SCALE:   cfg_min_scale_r <= cfg_data;
        CFG_FIRST_DELAY_SCALE: cfg_fd_scale_r  <= cfg_data[15:0];
        CFG_SQRT_NUMERATOR:    cfg_sq_num_r    <= cfg_data;
        CFG_MAX_STEP_SCALE:    cfg_ms_scale_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and ramp state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_STOP;
      dir_r         <= 1'b0;
      busy_r        <= 1'b0;
      delay_r       <= '0;
      min_delay_r   <= '0;
      last_delay_r  <= '0;
      ramp_r        <= '0;
      brake_len_r   <= '0;
      brake_start_r <= '0;
      steps_done_r  <= '0;
      rem_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == CMD_MOVE) begin
              op_steps_r    <= abs_steps;
              op_acc_r      <= in_acc_rate;
              op_dec_r      <= in_dec_rate;
              op_spd_r      <= in_spd;
              dir_r         <= raw_steps[23];
              pend_period_r <= 32'd20;
              pend_cmp_r    <= 31'd10;
              pend_pe_r     <= 1'b0;
              state_r       <= S_MV0;
            end else begin
              pend_period_r <= 32'(delay_r);
              pend_cmp_r    <= 31'(delay_r >> 1);
              pend_pe_r     <= (phase_r != PH_STOP);
              state_r       <= S_TK0;
            end
          end
        end
        S_MV0: begin
          if (op_steps_r == 24'd1) begin
            // A single step brakes at once from a fixed delay.
            ramp_r       <= 32'hFFFF_FFFF;
            phase_r      <= PH_DECEL;
            delay_r      <= sat_delay(50'sd1000);
            busy_r       <= 1'b1;
            steps_done_r <= '0;
            rem_r        <= '0;
            state_r      <= S_DONE;
          end else if (op_steps_r == 24'd0) begin
            // An empty move only sets the direction.
            pend_period_r <= '0;
            pend_cmp_r    <= '0;
            state_r       <= S_DONE;
          end else begin
            state_r <= S_MV1W;
          end
        end
        S_MV1W: begin
          if (div_done) begin
            min_delay_r <= sat_delay($signed({2'b00, div_q}));
            state_r     <= S_SQW;
          end
        end
        S_SQW: begin
          if (div_done) begin
            sq_rem_r <= div_q[31:0];
            sq_res_r <= '0;
            sq_bit_r <= 31'h4000_0000;
            state_r  <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_take) begin
            sq_rem_r <= sq_rem_r - sq_trial[31:0];
          end
          sq_res_r <= (sq_res_r >> 1) + (sq_take ? 32'(sq_bit_r) : 32'd0);
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r == 31'd1) begin
            state_r <= S_SQ_END;
          end
        end
        S_SQ_END: begin
          state_r <= S_FD_DIV;
        end
        S_FD_DIV: begin
          state_r <= S_FD_W;
        end
        S_FD_W: begin
          delay_r <= sat_delay($signed({22'd0, recip_q}));
          state_r <= S_DV_DIV;
        end
        S_DV_DIV: begin
          state_r <= S_DV_W;
        end
        S_DV_W: begin
          divq_r  <= (recip_q == '0) ? 32'd1 : 32'(recip_q);
          state_r <= S_TL_DIV;
        end
        S_TL_DIV: begin
          state_r <= S_TL_W;
        end
        S_TL_W: begin
          if (div_done) begin
            top_lim_r <= q_nz;
            state_r   <= S_AL_DIV;
          end
        end
        S_AL_DIV: begin
          state_r <= S_AL_W;
        end
        S_AL_W: begin
          if (div_done) begin
            // A short move brakes after its acceleration share; a long one
            // brakes for a length set by the speed reached.
            if (q_nz <= top_lim_r) begin
              blen_r  <= q_nz - 32'(op_steps_r);
              state_r <= S_MV_END;
            end else begin
              state_r <= S_BL_DIV;
            end
          end
        end
        S_BL_DIV: begin
          state_r <= S_BL_W;
        end
        S_BL_W: begin
          if (div_done) begin
            blen_r  <= (div_q == '0) ? 32'hFFFF_FFFF : -div_q[31:0];
            state_r <= S_MV_END;
          end
        end
        S_MV_END: begin
          brake_len_r   <= blen_r;
          brake_start_r <= 32'(op_steps_r) + blen_r;
          if (delay_r <= min_delay_r) begin
            delay_r <= min_delay_r;
            phase_r <= PH_RUN;
          end else begin
            phase_r <= PH_ACCEL;
          end
          ramp_r       <= '0;
          steps_done_r <= '0;
          rem_r        <= '0;
          busy_r       <= 1'b1;
          state_r      <= S_DONE;
        end
        S_TK0: begin
          unique case (phase_r)
            PH_STOP: begin
              steps_done_r <= '0;
              rem_r        <= '0;
              busy_r       <= 1'b0;
              state_r      <= S_DONE;
            end
            PH_RUN: begin
              steps_done_r <= sd_inc;
              if (sd_inc >= brake_start_r) begin
                ramp_r  <= brake_len_r;
                delay_r <= last_delay_r;
                phase_r <= PH_DECEL;
              end else begin
                delay_r <= min_delay_r;
              end
              state_r <= S_DONE;
            end
            PH_ACCEL, PH_DECEL: begin
              steps_done_r <= sd_inc;
              ramp_r       <= n_next;
              den_neg_r    <= den_s[34];
              state_r      <= S_TK_W;
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_TK_W: begin
          if (div_done) begin
            rem_r   <= rem_sat;
            delay_r <= tick_next;
            state_r <= S_DONE;
            if (phase_r == PH_ACCEL) begin
              if (steps_done_r >= brake_start_r) begin
                ramp_r  <= brake_len_r;
                phase_r <= PH_DECEL;
              end else if (tick_next <= min_delay_r) begin
                // Top speed reached: cruise, keep the ramp delay for braking.
                last_delay_r <= tick_next;
                delay_r      <= min_delay_r;
                rem_r        <= '0;
                phase_r      <= PH_RUN;
              end
            end else if (!ramp_r[31]) begin
              phase_r <= PH_STOP;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_period_r <= pend_period_r;
            out_cmp_r    <= pend_cmp_r;
            out_pe_r     <= pend_pe_r;
            out_dir_r    <= dir_r;
            out_busy_r   <= busy_r;
            out_phase_r  <= phase_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_phase_r, out_busy_r, out_dir_r, out_pe_r,
                       out_cmp_r, out_period_r};

endmodule

// ===== sv/stpr_div.sv =====
// ---------------------------------------------------------------------------
// stpr_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_trapezoid_ramp_core_macros.svh"

module stpr_div
  import stpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  dvd_t dividend,
  input  dvs_t divisor,
  output logic done,
  output dvd_t quotient,
  output dvs_t remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  dvd_t             quo_r;
  dvs_t             rem_r;
  dvs_t             dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `STPR_ASSERT_NOW(a_no_restart, start, !busy_r, "divider restarted while busy")
  `STPR_ASSERT_NOW(a_rem_bound, busy_r, rem_r < dvs_r, "partial remainder not below divisor")
  `STPR_ASSERT_NEXT(a_start_busy, start, busy_r && !done_r, "divider did not begin after start")

endmodule
